// ===== sv/grid_point_table_interpolator_assert.svh =====
// Assertion macros shared by the checker.
`ifndef GRID_POINT_TABLE_INTERPOLATOR_ASSERT_SVH
`define GRID_POINT_TABLE_INTERPOLATOR_ASSERT_SVH

// Check a property on every edge outside reset.
`define GPTI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal holds while a beat stalls.
`define GPTI_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// ===== sv/gpti_pkg.sv =====
package gpti_pkg;
	localparam int VAL_BITS = 16;
	localparam int EST_BITS = 18;
	localparam int OUT_BITS = 3;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [OUT_BITS-1:0] OUT_EXACT = 3'd0;
	localparam logic [OUT_BITS-1:0] OUT_N     = 3'd1;
	localparam logic [OUT_BITS-1:0] OUT_W     = 3'd2;
	localparam logic [OUT_BITS-1:0] OUT_2D    = 3'd3;
	localparam logic [OUT_BITS-1:0] OUT_NONE  = 3'd4;

	localparam logic signed [EST_BITS-1:0] EST_NONE = -18'sd65536;
	localparam logic signed [EST_BITS-1:0] EST_MAX  = 18'sd131071;
	localparam logic signed [EST_BITS-1:0] EST_MIN  = -18'sd131072;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ADDR, ST_SCAN, ST_PICK, ST_L1, ST_D1, ST_L2, ST_D2,
		ST_L3, ST_D3, ST_OUT
	} gpti_state_t;

	typedef struct packed {
		logic signed [EST_BITS-1:0] estimate;
		logic [OUT_BITS-1:0]        outcome;
	} gpti_res_t;
endpackage

// ===== sv/gpti_if.sv =====
interface gpti_in_if #(parameter int COORD_BITS = 13) (input logic clk);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [COORD_BITS-1:0] mass_w;
	logic [COORD_BITS-1:0] mass_n;
	logic [15:0]           value_first;
	logic [15:0]           value_second;
	logic                  year_select;
	modport source (output valid, command, mass_w, mass_n, value_first, value_second,
		year_select, input ready);
	modport sink (input valid, command, mass_w, mass_n, value_first, value_second,
		year_select, output ready);
endinterface

interface gpti_out_if (input logic clk);
	logic               valid;
	logic               ready;
	logic signed [17:0] estimate;
	logic [2:0]         outcome;
	modport source (output valid, estimate, outcome, input ready);
	modport sink (input valid, estimate, outcome, output ready);
endinterface

// ===== sv/gpti_ram.sv =====
module gpti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/gpti_front.sv =====
module gpti_front import gpti_pkg::*; #(
	parameter int COORD_BITS = 13
) (
	input  logic clk,
	input  logic arst_n,
	gpti_in_if.sink in_ch,
	output logic                  q_valid,
	input  logic                  q_ready,
	output logic                  q_command,
	output logic [COORD_BITS-1:0] q_mass_w,
	output logic [COORD_BITS-1:0] q_mass_n,
	output logic [15:0]           q_value_first,
	output logic [15:0]           q_value_second,
	output logic                  q_year_select
);
	// two-entry queue between front and back
	localparam int QW = 1 + 2 * COORD_BITS + 32 + 1;
	logic [QW-1:0] fifo_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push, pop;
	logic [QW-1:0] head;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign head = fifo_q[rp_q];
	assign {q_command, q_mass_w, q_mass_n, q_value_first, q_value_second, q_year_select} = head;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= {in_ch.command, in_ch.mass_w, in_ch.mass_n, in_ch.value_first,
				in_ch.value_second, in_ch.year_select};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== sv/gpti_div.sv =====
module gpti_div #(
	parameter int NB = 48,
	parameter int DB = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NB-1:0] num,
	input  logic [DB-1:0] den,
	output logic          busy,
	output logic [NB-1:0] quo
);
	// restoring division, one quotient bit a cycle
	localparam int CB = $clog2(NB + 1);
	logic [NB-1:0] q_q;
	logic [DB:0]   r_q;
	logic [DB-1:0] d_q;
	logic [CB-1:0] cnt_q;
	logic [DB:0]   sh, diff;

	assign sh = {r_q[DB-1:0], q_q[NB-1]};
	assign diff = sh - {1'b0, d_q};
	assign busy = (cnt_q != '0);
	assign quo = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CB'(NB);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy) begin
			if (!diff[DB]) begin
				r_q <= diff;
				q_q <= {q_q[NB-2:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[NB-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== sv/gpti_back.sv =====
module gpti_back import gpti_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int COORD_BITS = 13
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic                  q_command,
	input  logic [COORD_BITS-1:0] q_mass_w,
	input  logic [COORD_BITS-1:0] q_mass_n,
	input  logic [15:0]           q_value_first,
	input  logic [15:0]           q_value_second,
	input  logic                  q_year_select,
	gpti_out_if.source out_ch
);
	localparam int AB = $clog2(TABLE_DEPTH);
	localparam int CNTB = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 2 * COORD_BITS + 32;
	localparam int SQB = 2 * COORD_BITS + 1;
	localparam int PB = COORD_BITS + 18;
	localparam int NB = PB + 1;
	localparam int DB = COORD_BITS;

	gpti_state_t st_q, st_nx;
	logic [CNTB-1:0] cnt_q;
	logic [AB-1:0]   idx_q;
	logic [COORD_BITS-1:0] qw_q, qn_q;
	logic sel_q;

	logic ram_we;
	logic [EW-1:0] rdata;
	logic [AB-1:0] raddr;

	// candidate slots: match, swl, swg, snl, sng, qll, qlg, qgl, qgg
	localparam int NS = 9;
	logic        v_q [NS];
	logic [COORD_BITS-1:0] cw_q [NS];
	logic [COORD_BITS-1:0] cn_q [NS];
	logic [15:0] cv_q [NS];
	logic [SQB-1:0] cd_q [NS];

	logic rv_s1;
	logic [AB-1:0] ridx_s1;
	logic [CNTB-1:0] scan_q;

	// stage s2: read entry fields and distance
	logic rv_s2;
	logic [COORD_BITS-1:0] pw_s2, pn_s2;
	logic [15:0] pv_s2;
	logic [SQB-1:0] pd_s2;
	logic [3:0] slot_s2;
	logic hit_s2;

	logic [COORD_BITS-1:0] pw, pn, dw, dn;
	logic [15:0] pv;

	gpti_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(cnt_q[AB-1:0]),
		.wdata({q_mass_w, q_mass_n, q_value_first, q_value_second}),
		.raddr(raddr), .rdata(rdata)
	);

	assign raddr = scan_q[AB-1:0];
	assign ram_we = (st_q == ST_IDLE) && q_valid && (q_command == CMD_ADD)
		&& (cnt_q != CNTB'(TABLE_DEPTH));
	assign pw = rdata[EW-1 -: COORD_BITS];
	assign pn = rdata[EW-1-COORD_BITS -: COORD_BITS];
	assign pv = sel_q ? rdata[15:0] : rdata[31:16];
	assign dw = (pw > qw_q) ? pw - qw_q : qw_q - pw;
	assign dn = (pn > qn_q) ? pn - qn_q : qn_q - pn;

	// interpolation datapath
	logic signed [NB-1:0] y1_q, ydiff_q;
	logic [DB-1:0] xd_q, den_q;
	logic signed [NB-1:0] va_q, res_q;
	logic neg_q;
	logic div_start, div_busy;
	logic [NB-1:0] div_num, div_quo;
	logic signed [NB-1:0] prod;
	logic signed [NB-1:0] step;
	logic [2:0] oc_q;
	logic [1:0] ph_q;
	logic [OUT_BITS-1:0] pick_oc;

	assign prod = $signed({1'b0, xd_q}) * ydiff_q;
	// divide the magnitude, restore the sign after
	assign div_num = prod[NB-1] ? NB'(-prod) : NB'(prod);
	gpti_div #(.NB(NB), .DB(DB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(den_q),
		.busy(div_busy), .quo(div_quo)
	);
	assign step = neg_q ? -$signed(div_quo) : $signed(div_quo);

	always_comb begin
		if (v_q[0]) pick_oc = OUT_EXACT;
		else if (v_q[1] && v_q[2]) pick_oc = OUT_N;
		else if (v_q[3] && v_q[4]) pick_oc = OUT_W;
		else if (v_q[5] && v_q[6] && v_q[7] && v_q[8]) pick_oc = OUT_2D;
		else pick_oc = OUT_NONE;
	end

	always_comb begin
		st_nx = st_q;
		case (st_q)
			ST_IDLE: if (q_valid && q_command == CMD_QUERY) st_nx = ST_ADDR;
			ST_ADDR: st_nx = ST_SCAN;
			ST_SCAN: if (!rv_s1 && !rv_s2 && scan_q >= cnt_q) st_nx = ST_PICK;
			ST_PICK: st_nx = (pick_oc == OUT_EXACT || pick_oc == OUT_NONE) ? ST_OUT : ST_L1;
			ST_L1: st_nx = ST_D1;
			ST_D1: if (!div_busy && !div_start)
				st_nx = (oc_q == OUT_2D && ph_q != 2'd2) ? ST_L2 : ST_OUT;
			ST_L2: st_nx = ST_D2;
			ST_D2: st_nx = ST_L3;
			ST_L3: st_nx = ST_D3;
			ST_D3: st_nx = ST_D1;
			ST_OUT: if (!out_ch.valid || out_ch.ready) st_nx = ST_IDLE;
			default: st_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = 1'b0;
		case (st_q)
			ST_IDLE: q_ready = q_valid && (q_command == CMD_ADD);
			ST_OUT: q_ready = !out_ch.valid || out_ch.ready;
			default: q_ready = 1'b0;
		endcase
	end

	assign div_start = (st_q == ST_L1) || (st_q == ST_D3);

	// slot classification for one entry
	always_comb begin
		slot_s2 = 4'd0;
		if (pw == qw_q && pn == qn_q) slot_s2 = 4'd0;
		else if (pw == qw_q) slot_s2 = (pn > qn_q) ? 4'd2 : 4'd1;
		else if (pn == qn_q) slot_s2 = (pw > qw_q) ? 4'd4 : 4'd3;
		else if (pn > qn_q) slot_s2 = (pw > qw_q) ? 4'd8 : 4'd6;
		else slot_s2 = (pw > qw_q) ? 4'd7 : 4'd5;
	end

	logic [SQB-1:0] dsq;
	assign dsq = SQB'(dw * dw) + SQB'(dn * dn);
	assign hit_s2 = 1'b0;

	always_ff @(posedge clk) begin
		pw_s2 <= pw;
		pn_s2 <= pn;
		pv_s2 <= pv;
		if (pw == qw_q) pd_s2 <= SQB'(dn);
		else if (pn == qn_q) pd_s2 <= SQB'(dw);
		else pd_s2 <= dsq;
	end

	logic [3:0] sl_s2;
	always_ff @(posedge clk) sl_s2 <= slot_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			rv_s1 <= 1'b0;
			rv_s2 <= 1'b0;
			out_ch.valid <= 1'b0;
			for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (ram_we) cnt_q <= cnt_q + 1'b1;
			rv_s1 <= (st_q == ST_SCAN || st_q == ST_ADDR) && (scan_q < cnt_q) && !v_q[0];
			rv_s2 <= rv_s1;
			if (st_q == ST_OUT && st_nx == ST_IDLE) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			if (st_q == ST_IDLE) begin
				for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
			end else if (rv_s2 && !v_q[0]) begin
				if (sl_s2 == 4'd0 || !v_q[sl_s2] || cd_q[sl_s2] > pd_s2) v_q[sl_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) begin
			scan_q <= '0;
			qw_q <= q_mass_w;
			qn_q <= q_mass_n;
			sel_q <= q_year_select;
		end else if ((st_q == ST_ADDR || st_q == ST_SCAN) && scan_q < cnt_q) begin
			scan_q <= scan_q + 1'b1;
		end
		ridx_s1 <= raddr;
		if (rv_s2 && !v_q[0]) begin
			if (sl_s2 == 4'd0 || !v_q[sl_s2] || cd_q[sl_s2] > pd_s2) begin
				cw_q[sl_s2] <= pw_s2;
				cn_q[sl_s2] <= pn_s2;
				cv_q[sl_s2] <= pv_s2;
				cd_q[sl_s2] <= pd_s2;
			end
		end
	end

	// load interpolation operands: ph 0 first lerp, 1 second, 2 along w
	always_ff @(posedge clk) begin
		case (st_q)
			ST_PICK: begin
				ph_q <= 2'd0;
				if (v_q[0]) begin
					oc_q <= OUT_EXACT;
					res_q <= NB'($signed({1'b0, cv_q[0]}));
				end else if (v_q[1] && v_q[2]) begin
					oc_q <= OUT_N;
					y1_q <= NB'($signed({1'b0, cv_q[1]}));
					ydiff_q <= NB'($signed({1'b0, cv_q[2]})) - NB'($signed({1'b0, cv_q[1]}));
					xd_q <= qn_q - cn_q[1];
					den_q <= cn_q[2] - cn_q[1];
				end else if (v_q[3] && v_q[4]) begin
					oc_q <= OUT_W;
					y1_q <= NB'($signed({1'b0, cv_q[3]}));
					ydiff_q <= NB'($signed({1'b0, cv_q[4]})) - NB'($signed({1'b0, cv_q[3]}));
					xd_q <= qw_q - cw_q[3];
					den_q <= cw_q[4] - cw_q[3];
				end else if (v_q[5] && v_q[6] && v_q[7] && v_q[8]) begin
					oc_q <= OUT_2D;
					y1_q <= NB'($signed({1'b0, cv_q[5]}));
					ydiff_q <= NB'($signed({1'b0, cv_q[6]})) - NB'($signed({1'b0, cv_q[5]}));
					xd_q <= qn_q - cn_q[5];
					den_q <= cn_q[6] - cn_q[5];
				end else begin
					oc_q <= OUT_NONE;
					res_q <= NB'(EST_NONE);
				end
			end
			ST_L1: begin
				neg_q <= prod[NB-1];
			end
			ST_D3: begin
				neg_q <= prod[NB-1];
			end
			ST_D1: if (!div_busy && !div_start) begin
				res_q <= y1_q + step;
				if (ph_q == 2'd0) va_q <= y1_q + step;
			end
			ST_L2: begin
				if (ph_q == 2'd0) begin
					y1_q <= NB'($signed({1'b0, cv_q[7]}));
					ydiff_q <= NB'($signed({1'b0, cv_q[8]})) - NB'($signed({1'b0, cv_q[7]}));
					xd_q <= qn_q - cn_q[7];
					den_q <= cn_q[8] - cn_q[7];
				end else begin
					y1_q <= va_q;
					ydiff_q <= res_q - va_q;
					xd_q <= qw_q - cw_q[5];
					den_q <= cw_q[7] - cw_q[5];
				end
				ph_q <= ph_q + 2'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && st_nx == ST_IDLE) begin
			out_ch.outcome <= oc_q;
			if (res_q > NB'(EST_MAX)) out_ch.estimate <= EST_MAX;
			else if (res_q < NB'(EST_MIN)) out_ch.estimate <= EST_MIN;
			else out_ch.estimate <= res_q[EST_BITS-1:0];
		end
	end

	logic unused;
	assign unused = hit_s2 ^ ^ridx_s1;
endmodule

// ===== sv/grid_point_table_interpolator.sv =====
// channel | dir | payload
// in_ch   | in  | command, mass_w, mass_n, value_first, value_second, year_select
// out_ch  | out | estimate, outcome (queries only)
// A query scans every stored point, one per cycle through the table RAM read
// port, then runs up to three serial divisions. Reset empties the table at
// once; no clearing pass. A two-beat queue holds items while the back end
// works; a stalled result holds the back end.
module grid_point_table_interpolator import gpti_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int COORD_BITS = 13
) (
	input logic clk,
	input logic arst_n,
	gpti_in_if.sink in_ch,
	gpti_out_if.source out_ch
);
	logic q_valid, q_ready, q_command, q_year_select;
	logic [COORD_BITS-1:0] q_mass_w, q_mass_n;
	logic [15:0] q_value_first, q_value_second;

	gpti_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_valid(q_valid), .q_ready(q_ready), .q_command(q_command),
		.q_mass_w(q_mass_w), .q_mass_n(q_mass_n), .q_value_first(q_value_first),
		.q_value_second(q_value_second), .q_year_select(q_year_select)
	);

	gpti_back #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_command(q_command),
		.q_mass_w(q_mass_w), .q_mass_n(q_mass_n), .q_value_first(q_value_first),
		.q_value_second(q_value_second), .q_year_select(q_year_select),
		.out_ch(out_ch)
	);
endmodule

// ===== sv/gpti_checker.sv =====
`include "grid_point_table_interpolator_assert.svh"
module gpti_checker import gpti_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] outcome,
	input logic [17:0] estimate
);
	`GPTI_HOLD(a_hold, clk, arst_n, out_valid, out_ready, estimate, "result changed while stalled")
	`GPTI_ASSERT(a_code, clk, arst_n, !out_valid || outcome <= OUT_NONE, "bad outcome code")
	`GPTI_ASSERT(a_none, clk, arst_n, !(out_valid && outcome == OUT_NONE) || estimate == EST_NONE, "none found estimate")
endmodule

bind grid_point_table_interpolator gpti_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.outcome(out_ch.outcome), .estimate(out_ch.estimate)
);
